/* design/spm_pkg.sv */
// Shared types, constants and helpers for the sparse polynomial multiplier.
// No dependencies; the multiplier and its checker import this package.
`default_nettype none

package spm_pkg;

  localparam int COEF_W  = 16;
  localparam int EXP_W   = 10;
  localparam int PCOEF_W = 32;
  localparam int PEXP_W  = 11;

  localparam logic [1:0] OP_LOAD_FIRST  = 2'd0;
  localparam logic [1:0] OP_LOAD_SECOND = 2'd1;
  localparam logic [1:0] OP_COMPUTE     = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAIR_RD,
    ST_PAIR_MUL,
    ST_SEARCH,
    ST_EMIT_RD,
    ST_EMIT_OUT,
    ST_EMPTY
  } state_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef;
    logic [EXP_W-1:0]         exp;
  } term_t;

  typedef struct packed {
    logic [PEXP_W-1:0]         exp;
    logic signed [PCOEF_W-1:0] coef;
  } prod_entry_t;

  function automatic logic signed [PCOEF_W-1:0] sat_add32(
    input logic signed [PCOEF_W-1:0] a,
    input logic signed [PCOEF_W-1:0] b
  );
    logic [PCOEF_W:0] s;
    s = {a[PCOEF_W-1], a} + {b[PCOEF_W-1], b};
    if (s[PCOEF_W] != s[PCOEF_W-1]) begin
      return s[PCOEF_W] ? {1'b1, {(PCOEF_W-1){1'b0}}} : {1'b0, {(PCOEF_W-1){1'b1}}};
    end
    return s[PCOEF_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* design/spm_ram.sv */
// Single-port-write, single-port-read synchronous memory with registered read data.
// Used for both term stores and the product table; depends on nothing else.
`default_nettype none

module spm_ram #(
  parameter int DEPTH = 8,
  parameter int AW    = 3,
  parameter int W     = 26
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [W-1:0]  wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic [W-1:0]       rd_data
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* design/sparse_polynomial_multiply_unit.sv */
// Load items fill two term stores; a compute item multiplies all term pairs into
// a product table and then emits it. A load or an unused op is taken every cycle
// and a compute item holds the input stalled until its last result is loaded into
// the output register. Each pair is read, multiplied and then searched for in the
// product table, which is walked linearly one entry at a time through its single
// read port; each result is then read from the table and loaded into the output
// register. An empty product emits a single item.
`default_nettype none

module sparse_polynomial_multiply_unit
  import spm_pkg::*;
#(
  parameter int MAX_TERMS         = 8,
  parameter int MAX_PRODUCT_TERMS = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [1:0]                in_op,
  input  wire logic signed [COEF_W-1:0]  in_coef,
  input  wire logic [EXP_W-1:0]          in_exponent,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [PCOEF_W-1:0]      out_prod_coef,
  output logic [PEXP_W-1:0]              out_prod_exponent,
  output logic                           out_valid_res,
  output logic                           out_last,
  output logic                           out_overflow
);

  localparam int TIW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CW  = $clog2(MAX_TERMS + 1);
  localparam int PIW = (MAX_PRODUCT_TERMS > 1) ? $clog2(MAX_PRODUCT_TERMS) : 1;
  localparam int PCW = $clog2(MAX_PRODUCT_TERMS + 1);

  state_t state_r, state_nxt;

  logic [CW-1:0]  fcount_r, fcount_nxt, scount_r, scount_nxt;
  logic [PCW-1:0] pcount_r, pcount_nxt;
  logic           drop_r, drop_nxt;
  logic [TIW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [PIW-1:0] k_r, k_nxt;
  logic signed [PCOEF_W-1:0] prod_r, prod_nxt;
  logic [PEXP_W-1:0]         esum_r, esum_nxt;

  logic                      out_valid_r;
  logic signed [PCOEF_W-1:0] out_coef_r;
  logic [PEXP_W-1:0]         out_exp_r;
  logic                      out_vres_r, out_last_r, out_ovf_r;

  logic        in_fire, out_free, out_load, f_full, s_full, p_full;
  logic        j_end, i_end, pair_last, k_end, hit, search_done;
  logic        fa_we, sa_we, t_re, p_we, p_re;
  logic [PIW-1:0] p_waddr, p_raddr;
  term_t       t_wdata, f_rd, s_rd;
  prod_entry_t p_wdata, p_rd;

  spm_ram #(.DEPTH(MAX_TERMS), .AW(TIW), .W($bits(term_t))) u_first (
    .clk(clk), .wr_en(fa_we), .wr_addr(fcount_r[TIW-1:0]), .wr_data(t_wdata),
    .rd_en(t_re), .rd_addr(i_r), .rd_data(f_rd)
  );

  spm_ram #(.DEPTH(MAX_TERMS), .AW(TIW), .W($bits(term_t))) u_second (
    .clk(clk), .wr_en(sa_we), .wr_addr(scount_r[TIW-1:0]), .wr_data(t_wdata),
    .rd_en(t_re), .rd_addr(j_r), .rd_data(s_rd)
  );

  spm_ram #(.DEPTH(MAX_PRODUCT_TERMS), .AW(PIW), .W($bits(prod_entry_t))) u_prod (
    .clk(clk), .wr_en(p_we), .wr_addr(p_waddr), .wr_data(p_wdata),
    .rd_en(p_re), .rd_addr(p_raddr), .rd_data(p_rd)
  );

  assign t_wdata     = {in_coef, in_exponent};
  assign in_fire     = in_valid && !in_stall;
  assign out_free    = !out_valid_r || !out_stall;
  assign f_full      = (fcount_r == CW'(MAX_TERMS));
  assign s_full      = (scount_r == CW'(MAX_TERMS));
  assign p_full      = (pcount_r == PCW'(MAX_PRODUCT_TERMS));
  assign j_end       = (CW'(j_r) + CW'(1) == scount_r);
  assign i_end       = (CW'(i_r) + CW'(1) == fcount_r);
  assign pair_last   = i_end && j_end;
  assign k_end       = (PCW'(k_r) + PCW'(1) == pcount_r);
  assign hit         = (pcount_r != '0) && (p_rd.exp == esum_r);
  assign search_done = hit || k_end || (pcount_r == '0);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && in_op == OP_COMPUTE) begin
          state_nxt = (fcount_r == '0 || scount_r == '0) ? ST_EMPTY : ST_PAIR_RD;
        end
      end
      ST_PAIR_RD:  state_nxt = ST_PAIR_MUL;
      ST_PAIR_MUL: state_nxt = ST_SEARCH;
      ST_SEARCH: begin
        if (search_done) begin
          state_nxt = pair_last ? ST_EMIT_RD : ST_PAIR_RD;
        end
      end
      ST_EMIT_RD:  state_nxt = ST_EMIT_OUT;
      ST_EMIT_OUT: begin
        if (out_free) begin
          state_nxt = k_end ? ST_IDLE : ST_EMIT_RD;
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    fa_we    = 1'b0;
    sa_we    = 1'b0;
    t_re     = 1'b0;
    p_we     = 1'b0;
    p_waddr  = k_r;
    p_wdata  = {p_rd.exp, sat_add32(p_rd.coef, prod_r)};
    p_re     = 1'b0;
    p_raddr  = k_r;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        fa_we    = in_fire && in_op == OP_LOAD_FIRST && !f_full;
        sa_we    = in_fire && in_op == OP_LOAD_SECOND && !s_full;
      end
      ST_PAIR_RD: t_re = 1'b1;
      ST_PAIR_MUL: begin
        p_re    = 1'b1;
        p_raddr = '0;
      end
      ST_SEARCH: begin
        if (hit) begin
          p_we = 1'b1;
        end else if (search_done) begin
          p_we    = !p_full;
          p_waddr = pcount_r[PIW-1:0];
          p_wdata = {esum_r, prod_r};
        end else begin
          p_re    = 1'b1;
          p_raddr = k_r + PIW'(1);
        end
      end
      ST_EMIT_RD:  p_re = 1'b1;
      ST_EMIT_OUT: out_load = out_free;
      ST_EMPTY:    out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    fcount_nxt = fcount_r;
    scount_nxt = scount_r;
    pcount_nxt = pcount_r;
    drop_nxt   = drop_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    k_nxt      = k_r;
    prod_nxt   = prod_r;
    esum_nxt   = esum_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_op)
            OP_LOAD_FIRST: begin
              if (f_full) drop_nxt = 1'b1;
              else fcount_nxt = fcount_r + CW'(1);
            end
            OP_LOAD_SECOND: begin
              if (s_full) drop_nxt = 1'b1;
              else scount_nxt = scount_r + CW'(1);
            end
            OP_COMPUTE: begin
              i_nxt = '0;
              j_nxt = '0;
              k_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      ST_PAIR_MUL: begin
        prod_nxt = PCOEF_W'(f_rd.coef) * PCOEF_W'(s_rd.coef);
        esum_nxt = PEXP_W'(f_rd.exp) + PEXP_W'(s_rd.exp);
        k_nxt    = '0;
      end
      ST_SEARCH: begin
        if (!search_done) begin
          k_nxt = k_r + PIW'(1);
        end else begin
          if (!hit && !p_full) pcount_nxt = pcount_r + PCW'(1);
          k_nxt = '0;
          if (j_end) begin
            j_nxt = '0;
            i_nxt = i_r + TIW'(1);
          end else begin
            j_nxt = j_r + TIW'(1);
          end
        end
      end
      ST_EMIT_OUT: begin
        if (out_free) begin
          if (k_end) begin
            fcount_nxt = '0;
            scount_nxt = '0;
            pcount_nxt = '0;
            drop_nxt   = 1'b0;
            k_nxt      = '0;
          end else begin
            k_nxt = k_r + PIW'(1);
          end
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          fcount_nxt = '0;
          scount_nxt = '0;
          pcount_nxt = '0;
          drop_nxt   = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fcount_r    <= '0;
      scount_r    <= '0;
      pcount_r    <= '0;
      drop_r      <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fcount_r    <= fcount_nxt;
      scount_r    <= scount_nxt;
      pcount_r    <= pcount_nxt;
      drop_r      <= drop_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_load || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    esum_r <= esum_nxt;
    if (out_load) begin
      out_ovf_r  <= drop_r;
      out_last_r <= (state_r == ST_EMPTY) || k_end;
      if (state_r == ST_EMPTY) begin
        out_coef_r <= '0;
        out_exp_r  <= '0;
        out_vres_r <= 1'b0;
      end else begin
        out_coef_r <= p_rd.coef;
        out_exp_r  <= p_rd.exp;
        out_vres_r <= 1'b1;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_prod_coef     = out_coef_r;
  assign out_prod_exponent = out_exp_r;
  assign out_valid_res     = out_vres_r;
  assign out_last          = out_last_r;
  assign out_overflow      = out_ovf_r;

endmodule

`default_nettype wire

/* design/spm_checker.sv */
// Port-level checks on the sparse polynomial multiplier, bound to its top level.
// Depends on spm_pkg and on sparse_polynomial_multiply_unit.
`default_nettype none

module spm_checker
  import spm_pkg::*;
(
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_valid,
  input wire logic                      in_stall,
  input wire logic [1:0]                in_op,
  input wire logic                      out_valid,
  input wire logic                      out_stall,
  input wire logic signed [PCOEF_W-1:0] out_prod_coef,
  input wire logic [PEXP_W-1:0]         out_prod_exponent,
  input wire logic                      out_valid_res,
  input wire logic                      out_last
);

  // A stalled result holds until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_prod_coef)
      && $stable(out_prod_exponent) && $stable(out_last))
    else $error("stalled result changed");

  // An empty-product item is always the last of its run.
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |-> out_last)
    else $error("empty product item not marked last");

  // An empty-product item carries zero coefficient and exponent.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |-> out_prod_coef == '0 && out_prod_exponent == '0)
    else $error("empty product item carries data");

  // A compute transfer stalls the input on the following cycle.
  a_compute_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_op == OP_COMPUTE |=> in_stall)
    else $error("input not stalled after compute");

  // Product exponents never reach all ones, which lies above the largest sum of two input exponents.
  a_exp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_prod_exponent != {PEXP_W{1'b1}})
    else $error("product exponent out of range");

endmodule

bind sparse_polynomial_multiply_unit spm_checker u_spm_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .in_op(in_op),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_prod_coef(out_prod_coef),
  .out_prod_exponent(out_prod_exponent),
  .out_valid_res(out_valid_res),
  .out_last(out_last)
);

`default_nettype wire
